// ===== design/assert_macros.svh =====
// assert_macros.svh: assertion macros shared by the frustum plane extractor RTL.
// No dependencies; compiled ahead of the package and modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define FPE_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define FPE_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`else
`define FPE_ASSERT(name, clk, rst_n, prop)
`define FPE_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

// ===== design/fpe_pkg.sv =====
// fpe_pkg: types and constants of the frustum plane extractor.
// No dependencies; used by every module and by the top level.
package fpe_pkg;

  localparam int VW     = 32;          // value width, Q16.16
  localparam int FB     = 16;          // fraction bits
  localparam int MAG_W  = VW + 1;      // magnitude of a row sum or difference
  localparam int KMAX   = FB + 29;     // largest fraction shift of the offset divide
  localparam int DIV_W  = MAG_W + KMAX;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_EXTRACT = 2'd1,
    OP_QUERY   = 2'd2,
    OP_NONE    = 2'd3
  } opcode_e;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [3:0]        element_index;
    logic signed [31:0] element_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } in_item_t;

  typedef struct packed {
    logic              result_kind;
    logic [2:0]        plane_number;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic signed [31:0] plane_offset;
    logic signed [31:0] point_distance;
    logic              degenerate;
    logic              last_of_run;
  } out_item_t;

  // plane order near, far, left, right, top, bottom
  localparam logic [1:0] PLANE_ROW [6] = '{2'd2, 2'd2, 2'd0, 2'd0, 2'd1, 2'd1};
  localparam logic       PLANE_SUB [6] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
  localparam logic [2:0] LAST_PLANE = 3'd5;

  function automatic logic [MAG_W-1:0] mag_of(input logic signed [MAG_W-1:0] v);
    return v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);
  endfunction

endpackage

// ===== design/fpe_stream_if.sv =====
// fpe_stream_if: valid/ready channel carrying one word of type T.
// No dependencies; the payload type comes from fpe_pkg at the instance.
interface fpe_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/frustum_plane_extractor_core.sv =====
// frustum_plane_extractor_core: top level of the frustum plane extractor.
// Depends on fpe_pkg, fpe_stream_if, fpe_front and fpe_engine.
//
// Usage: in_i carries one word per command (opcode, element index and value,
// query point); out_o carries one result word per plane. Both channels move a
// word when valid and ready are high at a rising edge of clk_i.
// A load writes one matrix element and gives no result; opcode 3 is dropped.
// An extract builds the six planes in turn: matrix reads, one-bit normalising
// shifts, the square sum, the square root and four divides on the serial
// divider, which takes the longest. A query works plane by plane: three
// multiplies on one multiplier, one add and one output step for each of its
// six results.
// A two-word command queue lets the input side keep taking words while the
// back end works; in_i.ready drops only when the queue is full.
// When out_o.ready is low the finished word waits in the output register and
// the back end stalls before the next result; nothing is dropped.
// Reset (rst_ni low, asynchronous) clears the matrix, the stored planes and
// their degenerate marks to zero and empties the queue.
module frustum_plane_extractor_core import fpe_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  fpe_stream_if.sink    in_i,
  fpe_stream_if.source  out_o
);

  logic     q_valid, q_pop;
  in_item_t q_cmd;

  fpe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_data_i  (in_i.data),
    .in_ready_o (in_i.ready),
    .q_valid_o  (q_valid),
    .q_cmd_o    (q_cmd),
    .q_pop_i    (q_pop)
  );

  fpe_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_cmd),
    .q_pop_o     (q_pop),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_o.data),
    .out_ready_i (out_o.ready)
  );

endmodule

// ===== design/fpe_front.sv =====
// fpe_front: input side; accepts words, drops unused opcodes, queues commands.
// Depends on fpe_pkg and assert_macros.svh.
`include "assert_macros.svh"
module fpe_front import fpe_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  in_item_t in_data_i,
  output logic     in_ready_o,
  output logic     q_valid_o,
  output in_item_t q_cmd_o,
  input  logic     q_pop_i
);

  in_item_t   buf_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;

  assign in_ready_o = (cnt_q != 2'd2);
  // opcode 3 is taken and discarded
  assign push       = in_valid_i && in_ready_o && (opcode_e'(in_data_i.opcode) != OP_NONE);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_cmd_o    = buf_q[rd_ptr_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= in_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (q_pop_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

  `FPE_ASSERT(a_pop_nonempty, clk_i, rst_ni, q_pop_i |-> cnt_q != 2'd0)

endmodule

// ===== design/fpe_div.sv =====
// fpe_div: restoring divider, one quotient bit per cycle.
// Depends on fpe_pkg.
module fpe_div import fpe_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [31:0]      divisor_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [DIV_W-1:0] quot_o
);

  localparam int CW = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] x_q;
  logic [31:0]      r_q, d_q;
  logic [CW-1:0]    cnt_q;
  logic             done_q;
  logic [32:0]      rs;
  logic             qbit;

  // trial subtract
  always_comb begin
    rs   = {r_q, x_q[DIV_W-1]};
    qbit = (rs >= {1'b0, d_q});
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= dividend_i;
      r_q <= '0;
      d_q <= divisor_i;
    end else if (cnt_q != '0) begin
      x_q <= {x_q[DIV_W-2:0], qbit};
      r_q <= qbit ? 32'(rs - {1'b0, d_q}) : rs[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CW'(1));
      if (start_i) cnt_q <= CW'(DIV_W);
      else if (cnt_q != '0) cnt_q <= cnt_q - CW'(1);
    end
  end

  assign busy_o = (cnt_q != '0);
  assign done_o = done_q;
  assign quot_o = x_q;

endmodule

// ===== design/fpe_engine.sv =====
// fpe_engine: back end; matrix store, plane extraction, distance queries, result register.
// Depends on fpe_pkg, fpe_div and assert_macros.svh.
`include "assert_macros.svh"
module fpe_engine import fpe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  in_item_t  q_cmd_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  output out_item_t out_data_o,
  input  logic      out_ready_i
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_RAW    = 11'b00000000010,
    S_NRM0   = 11'b00000000100,
    S_NRM    = 11'b00000001000,
    S_SQ     = 11'b00000010000,
    S_SQRT   = 11'b00000100000,
    S_DSTART = 11'b00001000000,
    S_DWAIT  = 11'b00010000000,
    S_EMIT   = 11'b00100000000,
    S_QMUL   = 11'b01000000000,
    S_QFIN   = 11'b10000000000
  } state_e;

  state_e state_q;

  logic signed [31:0] matrix_q [16];
  logic signed [31:0] plane_q [6][4];
  logic [5:0]         degen_q;

  logic [2:0]         p_q, cnt_q;
  logic               query_q;
  logic signed [31:0] pt_q [3];
  logic signed [31:0] tmp_q;
  logic signed [32:0] raw_q [4];
  logic [MAG_W-1:0]   m_q [3];
  logic [MAG_W-1:0]   mx_q;
  logic signed [5:0]  s_q;
  logic [59:0]        prod_q;
  logic [61:0]        sum_q, n_q;
  logic [62:0]        res_q, bit_q;
  logic [31:0]        len_q;
  logic signed [31:0] cf_q [4];
  logic               dg_q;
  logic signed [63:0] qprod_q;
  logic signed [65:0] acc_q;
  logic signed [31:0] dist_q;
  logic               out_valid_q;
  out_item_t          out_q;

  // divider hookup
  logic             div_start, div_busy, div_done;
  logic [DIV_W-1:0] div_dividend, div_quot;

  fpe_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (len_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // matrix read: row 3 on even steps, plane row on odd steps
  logic [1:0]         col, crow;
  logic [3:0]         maddr;
  logic signed [31:0] mval;
  logic signed [32:0] raw_new;
  always_comb begin
    col     = cnt_q[2:1];
    crow    = PLANE_ROW[p_q];
    maddr   = cnt_q[0] ? {col, crow} : {col, 2'b11};
    mval    = matrix_q[maddr];
    raw_new = PLANE_SUB[p_q] ? ({tmp_q[31], tmp_q} - {mval[31], mval})
                             : ({tmp_q[31], tmp_q} + {mval[31], mval});
  end

  // magnitudes and maximum of the raw normal
  logic [MAG_W-1:0] a0, a1, a2, amx;
  always_comb begin
    a0  = mag_of(raw_q[0]);
    a1  = mag_of(raw_q[1]);
    a2  = mag_of(raw_q[2]);
    amx = (a0 > a1) ? a0 : a1;
    if (a2 > amx) amx = a2;
  end

  // square sum operand
  logic [29:0] sq_op;
  always_comb begin
    case (cnt_q[1:0])
      2'd0:    sq_op = m_q[0][29:0];
      2'd1:    sq_op = m_q[1][29:0];
      default: sq_op = m_q[2][29:0];
    endcase
  end

  // square root step
  logic [63:0] trial;
  logic        take;
  assign trial = {1'b0, res_q} + {1'b0, bit_q};
  assign take  = ({2'b00, n_q} >= trial);

  // divider operands: normal coefficients use the scaled magnitude, offset the raw one
  logic [1:0]        dc;
  logic signed [6:0] ksum;
  logic [MAG_W-1:0]  dmag;
  logic [5:0]        dk;
  always_comb begin
    dc   = cnt_q[1:0];
    ksum = 7'(FB) + {s_q[5], s_q};
    case (dc)
      2'd0:    begin dmag = m_q[0]; dk = 6'(FB); end
      2'd1:    begin dmag = m_q[1]; dk = 6'(FB); end
      2'd2:    begin dmag = m_q[2]; dk = 6'(FB); end
      default: begin dmag = mag_of(raw_q[3]); dk = ksum[5:0]; end
    endcase
    div_dividend = {{(DIV_W-MAG_W){1'b0}}, dmag} << dk;
    div_start    = (state_q == S_DSTART);
  end

  // quotient saturation, sign restored
  logic               qneg;
  logic signed [31:0] qval;
  always_comb begin
    qneg = raw_q[dc][32];
    if (qneg) begin
      if ((div_quot[DIV_W-1:32] != '0) || (div_quot[31] && (div_quot[30:0] != '0)))
        qval = 32'sh8000_0000;
      else
        qval = -$signed(div_quot[31:0]);
    end else begin
      if (div_quot[DIV_W-1:31] != '0) qval = 32'sh7fff_ffff;
      else qval = $signed(div_quot[31:0]);
    end
  end

  // distance: floor shift plus offset, saturated
  logic signed [66:0] dsum;
  logic signed [65:0] ash;
  always_comb begin
    ash  = acc_q >>> FB;
    dsum = {ash[65], ash} + {{35{plane_q[p_q][3][31]}}, plane_q[p_q][3]};
  end

  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;
  assign q_pop_o  = (state_q == S_IDLE) && q_valid_i;

  // result valid: set on emit, cleared when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == S_EMIT) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // stores and control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      degen_q     <= '0;
      p_q         <= '0;
      cnt_q       <= '0;
      query_q     <= 1'b0;
      for (int i = 0; i < 16; i++) matrix_q[i] <= '0;
      for (int i = 0; i < 6; i++) begin
        for (int j = 0; j < 4; j++) plane_q[i][j] <= '0;
      end
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            p_q   <= '0;
            cnt_q <= '0;
            case (opcode_e'(q_cmd_i.opcode))
              OP_LOAD: matrix_q[q_cmd_i.element_index] <= q_cmd_i.element_value;
              OP_EXTRACT: begin
                query_q <= 1'b0;
                state_q <= S_RAW;
              end
              default: begin
                query_q <= 1'b1;
                state_q <= S_QMUL;
              end
            endcase
          end
        end
        S_RAW: begin
          cnt_q <= cnt_q + 3'd1;
          if (cnt_q == 3'd7) state_q <= S_NRM0;
        end
        S_NRM0: begin
          state_q <= (amx == '0) ? S_EMIT : S_NRM;
        end
        S_NRM: begin
          if (mx_q[MAG_W-1:30] == '0 && mx_q[29]) begin
            cnt_q   <= '0;
            state_q <= S_SQ;
          end
        end
        S_SQ: begin
          cnt_q <= cnt_q + 3'd1;
          if (cnt_q == 3'd3) state_q <= S_SQRT;
        end
        S_SQRT: begin
          if (bit_q == '0) begin
            cnt_q   <= '0;
            state_q <= S_DSTART;
          end
        end
        S_DSTART: state_q <= S_DWAIT;
        S_DWAIT: begin
          if (div_done) begin
            cnt_q   <= cnt_q + 3'd1;
            state_q <= (dc == 2'd3) ? S_EMIT : S_DSTART;
          end
        end
        S_QMUL: begin
          cnt_q <= cnt_q + 3'd1;
          if (cnt_q == 3'd3) state_q <= S_QFIN;
        end
        S_QFIN: state_q <= S_EMIT;
        S_EMIT: begin
          if (out_free) begin
            if (!query_q) begin
              for (int j = 0; j < 4; j++) plane_q[p_q][j] <= cf_q[j];
              degen_q[p_q] <= dg_q;
            end
            cnt_q <= '0;
            if (p_q == LAST_PLANE) begin
              state_q <= S_IDLE;
            end else begin
              p_q     <= p_q + 3'd1;
              state_q <= query_q ? S_QMUL : S_RAW;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        pt_q[0] <= q_cmd_i.point_x;
        pt_q[1] <= q_cmd_i.point_y;
        pt_q[2] <= q_cmd_i.point_z;
        acc_q   <= '0;
      end
      S_RAW: begin
        if (!cnt_q[0]) tmp_q <= mval;
        else raw_q[col] <= raw_new;
      end
      S_NRM0: begin
        m_q[0] <= a0;
        m_q[1] <= a1;
        m_q[2] <= a2;
        mx_q   <= amx;
        s_q    <= '0;
        sum_q  <= '0;
        if (amx == '0) begin
          for (int j = 0; j < 4; j++) cf_q[j] <= '0;
          dg_q <= 1'b1;
        end
      end
      // bring the largest magnitude into [2^29, 2^30), one bit a cycle
      S_NRM: begin
        if (mx_q[MAG_W-1:30] != '0) begin
          mx_q <= mx_q >> 1;
          for (int j = 0; j < 3; j++) m_q[j] <= m_q[j] >> 1;
          s_q  <= s_q - 6'sd1;
        end else if (!mx_q[29]) begin
          mx_q <= mx_q << 1;
          for (int j = 0; j < 3; j++) m_q[j] <= m_q[j] << 1;
          s_q  <= s_q + 6'sd1;
        end
      end
      S_SQ: begin
        if (cnt_q != 3'd3) prod_q <= sq_op * sq_op;
        if (cnt_q != 3'd0) sum_q <= sum_q + 62'(prod_q);
        if (cnt_q == 3'd3) begin
          n_q   <= sum_q + 62'(prod_q);
          res_q <= '0;
          bit_q <= 63'(1) << 62;
        end
      end
      S_SQRT: begin
        if (bit_q != '0) begin
          if (take) begin
            n_q   <= n_q - trial[61:0];
            res_q <= (res_q >> 1) + bit_q;
          end else begin
            res_q <= res_q >> 1;
          end
          bit_q <= bit_q >> 2;
        end else begin
          len_q <= res_q[31:0];
        end
      end
      S_DWAIT: begin
        if (div_done) begin
          cf_q[dc] <= qval;
          dg_q     <= 1'b0;
        end
      end
      S_QMUL: begin
        if (cnt_q != 3'd3) qprod_q <= pt_q[cnt_q[1:0]] * plane_q[p_q][cnt_q[1:0]];
        if (cnt_q != 3'd0) acc_q <= acc_q + {{2{qprod_q[63]}}, qprod_q};
      end
      S_QFIN: begin
        if (!dsum[66] && (dsum[65:31] != '0)) dist_q <= 32'sh7fff_ffff;
        else if (dsum[66] && !(&dsum[65:31])) dist_q <= 32'sh8000_0000;
        else dist_q <= dsum[31:0];
      end
      S_EMIT: begin
        acc_q <= '0;
        if (out_free) begin
          out_q.result_kind    <= query_q;
          out_q.plane_number   <= p_q;
          out_q.last_of_run    <= (p_q == LAST_PLANE);
          out_q.normal_x       <= query_q ? plane_q[p_q][0] : cf_q[0];
          out_q.normal_y       <= query_q ? plane_q[p_q][1] : cf_q[1];
          out_q.normal_z       <= query_q ? plane_q[p_q][2] : cf_q[2];
          out_q.plane_offset   <= query_q ? plane_q[p_q][3] : cf_q[3];
          out_q.point_distance <= query_q ? dist_q : '0;
          out_q.degenerate     <= query_q ? degen_q[p_q] : dg_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `FPE_ASSERT(a_div_only_waiting, clk_i, rst_ni, div_busy |-> state_q == S_DWAIT)
  `FPE_ASSERT(a_nrm_nonzero, clk_i, rst_ni, state_q == S_NRM |-> mx_q != '0)
  `FPE_ASSERT(a_len_normalised, clk_i, rst_ni, state_q == S_DSTART |-> len_q[31:29] != 3'b000)

endmodule
